// ===== src/ppsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shortest path package
// Shared constants, codes, controller states and the command and status
// structures that join the controller and the datapath.
// ----------------------------------------------------------------------------
package ppsp_pkg;

    localparam int NODES       = 64;
    localparam int NODE_W      = $clog2(NODES);
    localparam int ADDR_W      = 2 * NODE_W;
    localparam int WEIGHT_BITS = 16;
    localparam int ENTRY_W     = WEIGHT_BITS + 1;
    localparam int DIST_W      = 22;
    localparam int SUM_W       = DIST_W + 1;
    localparam int OUT_W       = 23;
    localparam int OPCODE_W    = 2;
    localparam int FIELD_NODE_W = 6;
    localparam int FIELD_WEIGHT_W = 16;

    typedef enum logic [OPCODE_W-1:0] {
        OP_EDGE  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_QUERY = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RELAX,
        ST_DRAIN,
        ST_DECIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic sweep;
        logic edge_write;
        logic load_query;
        logic pass_start;
        logic issue;
        logic settle;
        logic load_result;
    } ppsp_cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic col_last;
        logic pipe_busy;
        logic any;
        logic pick_is_target;
        logic out_busy;
    } ppsp_sts_t;

endpackage

// ===== src/ppsp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shortest path controller
// Sequences the clearing sweep, edge writes and the relax and select passes
// of a query, and decides when a query is finished.
// ----------------------------------------------------------------------------
module ppsp_ctrl import ppsp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic [OPCODE_W-1:0] opcode,
    input  ppsp_sts_t           sts,
    output ppsp_cmd_t           cmd,
    output logic                req_stall
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (op_t'(opcode))
                        OP_CLEAR: state_next = ST_CLEAR;
                        OP_QUERY: state_next = ST_RELAX;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RELAX:
            begin
                if (sts.col_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!sts.any || sts.pick_is_target)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_RELAX;
                end
            end
            ST_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.sweep = 1'b1;
            end
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    case (op_t'(opcode))
                        OP_EDGE:
                        begin
                            cmd.edge_write = 1'b1;
                        end
                        OP_QUERY:
                        begin
                            cmd.load_query = 1'b1;
                            cmd.pass_start = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RELAX:
            begin
                cmd.issue = 1'b1;
            end
            ST_DECIDE:
            begin
                if (sts.any && !sts.pick_is_target)
                begin
                    cmd.settle     = 1'b1;
                    cmd.pass_start = 1'b1;
                end
            end
            ST_FINISH:
            begin
                cmd.load_result = !sts.out_busy;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== src/ppsp_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shortest path datapath
// Holds the adjacency memory, the distance memory and the node marks, and
// runs a two-stage relax pass that also tracks the nearest unsettled node.
// ----------------------------------------------------------------------------
module ppsp_datapath import ppsp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  ppsp_cmd_t                 cmd,
    output ppsp_sts_t                 sts,
    input  logic [FIELD_NODE_W-1:0]   from_node,
    input  logic [FIELD_NODE_W-1:0]   to_node,
    input  logic [FIELD_WEIGHT_W-1:0] weight,
    input  logic                      edge_present,
    input  logic [FIELD_NODE_W-1:0]   source_node,
    input  logic [FIELD_NODE_W-1:0]   target_node,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output logic signed [OUT_W-1:0]   distance,
    output logic                      found
);

    logic [ENTRY_W-1:0] adj_mem [0:(1 << ADDR_W)-1];
    logic [DIST_W-1:0]  dist_mem [0:NODES-1];

    logic [ADDR_W-1:0]  sweep_reg;
    logic [NODE_W-1:0]  col_reg;
    logic [NODES-1:0]   reached_reg;
    logic [NODES-1:0]   settled_reg;
    logic               s1_valid_reg;
    logic               s2_valid_reg;
    logic               any_reg;
    logic               out_valid_reg;

    logic [NODE_W-1:0]  row_reg;
    logic [NODE_W-1:0]  target_reg;
    logic [DIST_W-1:0]  base_reg;
    logic [NODE_W-1:0]  j1_reg;
    logic [ENTRY_W-1:0] adj_rd_reg;
    logic [DIST_W-1:0]  dist_rd_reg;
    logic [NODE_W-1:0]  cand_idx_reg;
    logic [DIST_W-1:0]  cand_val_reg;
    logic               cand_ok_reg;
    logic [DIST_W-1:0]  best_reg;
    logic [NODE_W-1:0]  pick_reg;
    logic [OUT_W-1:0]   distance_reg;
    logic               found_reg;

    logic               adj_we;
    logic [ADDR_W-1:0]  adj_waddr;
    logic [ENTRY_W-1:0] adj_wdata;
    logic [ADDR_W-1:0]  adj_raddr;
    logic [SUM_W-1:0]   sum;
    logic [DIST_W-1:0]  relaxed;
    logic               upd;
    logic               take_min;

    always_comb
    begin
        adj_we    = cmd.sweep || cmd.edge_write;
        adj_waddr = sweep_reg;
        adj_wdata = '0;
        if (cmd.edge_write)
        begin
            adj_waddr = {from_node[NODE_W-1:0], to_node[NODE_W-1:0]};
            if (edge_present)
            begin
                adj_wdata = {1'b1, weight[WEIGHT_BITS-1:0]};
            end
        end
        adj_raddr = {row_reg, col_reg};
    end

    always_ff @(posedge clk)
    begin
        if (adj_we)
        begin
            adj_mem[adj_waddr] <= adj_wdata;
        end
        adj_rd_reg <= adj_mem[adj_raddr];
    end

    always_comb
    begin
        sum     = {1'b0, base_reg} + {{(SUM_W-WEIGHT_BITS){1'b0}}, adj_rd_reg[WEIGHT_BITS-1:0]};
        relaxed = sum[SUM_W-1] ? '1 : sum[DIST_W-1:0];
        upd     = adj_rd_reg[ENTRY_W-1] && !settled_reg[j1_reg] &&
                  (!reached_reg[j1_reg] || relaxed < dist_rd_reg);
        take_min = s2_valid_reg && cand_ok_reg && (!any_reg || cand_val_reg < best_reg);
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && upd)
        begin
            dist_mem[j1_reg] <= relaxed;
        end
        dist_rd_reg <= dist_mem[col_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg     <= '0;
            col_reg       <= '0;
            reached_reg   <= '0;
            settled_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            any_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.sweep)
            begin
                sweep_reg <= sweep_reg + 1'b1;
            end
            if (cmd.pass_start)
            begin
                col_reg <= '0;
            end
            else if (cmd.issue)
            begin
                col_reg <= col_reg + 1'b1;
            end
            if (cmd.load_query)
            begin
                reached_reg <= '0;
                settled_reg <= '0;
            end
            else
            begin
                if (s1_valid_reg && upd)
                begin
                    reached_reg[j1_reg] <= 1'b1;
                end
                if (cmd.settle)
                begin
                    settled_reg[pick_reg] <= 1'b1;
                end
            end
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
            if (cmd.pass_start)
            begin
                any_reg <= 1'b0;
            end
            else if (take_min)
            begin
                any_reg <= 1'b1;
            end
            if (cmd.load_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            row_reg    <= source_node[NODE_W-1:0];
            target_reg <= target_node[NODE_W-1:0];
            base_reg   <= '0;
        end
        else if (cmd.settle)
        begin
            row_reg  <= pick_reg;
            base_reg <= best_reg;
        end
        j1_reg       <= col_reg;
        cand_idx_reg <= j1_reg;
        cand_val_reg <= upd ? relaxed : dist_rd_reg;
        cand_ok_reg  <= (reached_reg[j1_reg] || upd) && !settled_reg[j1_reg];
        if (take_min)
        begin
            best_reg <= cand_val_reg;
            pick_reg <= cand_idx_reg;
        end
        if (cmd.load_result)
        begin
            distance_reg <= any_reg ? {1'b0, best_reg} : '1;
            found_reg    <= any_reg;
        end
    end

    always_comb
    begin
        sts.sweep_last     = &sweep_reg;
        sts.col_last       = &col_reg;
        sts.pipe_busy      = s1_valid_reg || s2_valid_reg;
        sts.any            = any_reg;
        sts.pick_is_target = pick_reg == target_reg;
        sts.out_busy       = out_valid_reg && rsp_stall;
    end

    assign rsp_valid = out_valid_reg;
    assign distance  = signed'(distance_reg);
    assign found     = found_reg;

endmodule

// ===== src/point_to_point_shortest_path_core.sv =====
// Edge write: taken from the idle state. Clear: one adjacency entry per cycle, 4096 entries in all.
// Query: each relax pass makes 64 memory reads, drains the pipeline and then decides;
// there is one pass for the source and one per settled node.
// Items are taken one at a time; a waiting result stalls only the finish of the next query.
// Reset: req_stall stays high during a pass that clears the adjacency memory.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-to-point shortest path core
// Keeps a directed weighted graph and answers single-pair shortest path
// queries with a scan-based Dijkstra search.
// ----------------------------------------------------------------------------
module point_to_point_shortest_path_core import ppsp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  logic [OPCODE_W-1:0]       opcode,
    input  logic [FIELD_NODE_W-1:0]   from_node,
    input  logic [FIELD_NODE_W-1:0]   to_node,
    input  logic [FIELD_WEIGHT_W-1:0] weight,
    input  logic                      edge_present,
    input  logic [FIELD_NODE_W-1:0]   source_node,
    input  logic [FIELD_NODE_W-1:0]   target_node,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output logic signed [OUT_W-1:0]   distance,
    output logic                      found
);

    ppsp_cmd_t cmd;
    ppsp_sts_t sts;

    ppsp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .opcode    (opcode),
        .sts       (sts),
        .cmd       (cmd),
        .req_stall (req_stall)
    );

    ppsp_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .from_node    (from_node),
        .to_node      (to_node),
        .weight       (weight),
        .edge_present (edge_present),
        .source_node  (source_node),
        .target_node  (target_node),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .distance     (distance),
        .found        (found)
    );

endmodule

// ===== src/ppsp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shortest path port checker
// Watches the ports of the core for result consistency and busy behavior.
// ----------------------------------------------------------------------------
module ppsp_checker import ppsp_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      req_valid,
    input logic                      req_stall,
    input logic [OPCODE_W-1:0]       opcode,
    input logic                      rsp_valid,
    input logic                      rsp_stall,
    input logic signed [OUT_W-1:0]   distance,
    input logic                      found
);

    // A stalled result must hold until its transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(distance) && $stable(found))
        else $error("stalled result changed");

    // A found path has a non-negative distance, and a miss reports all ones.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (found ? !distance[OUT_W-1] : (&distance)))
        else $error("found flag disagrees with distance");

    // A query keeps the block busy in the cycle after its transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && opcode == OP_QUERY |=> req_stall)
        else $error("query did not make the block busy");

    // A clear starts a sweep that holds off further input.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && opcode == OP_CLEAR |=> req_stall)
        else $error("clear did not make the block busy");

endmodule

bind point_to_point_shortest_path_core ppsp_checker u_checker (.*);
